[design/sol_pkg.sv]
// Shared types and constants of the stacking order list.
// No dependencies; compiled first.
package sol_pkg;

    localparam int OP_W     = 3;
    localparam int SLOT_W   = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_REMOVE = 3'd0,
        OP_TOP    = 3'd1,
        OP_BOTTOM = 3'd2,
        OP_ABOVE  = 3'd3,
        OP_BELOW  = 3'd4,
        OP_QUERY  = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_MEMBER = 2'd1,
        ST_REF    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WR1,
        S_WR2,
        S_FIN
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic rd_en;
        logic wr1;
        logic wr2;
        logic finish;
    } ctrl_t;

endpackage

[design/sol_if.sv]
// Request and response channel interfaces of the stacking order list.
// Depends on sol_pkg for field widths.
interface sol_req_if;
    import sol_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] reference_slot;

    modport source (output valid, output op, output slot, output reference_slot, input ready);
    modport sink   (input valid, input op, input slot, input reference_slot, output ready);
endinterface

interface sol_rsp_if;
    import sol_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                is_member;
    logic [SLOT_W-1:0]   top_slot;
    logic [SLOT_W-1:0]   bottom_slot;
    logic                list_empty;

    modport source (output valid, output status, output is_member, output top_slot,
                    output bottom_slot, output list_empty, input ready);
    modport sink   (input valid, input status, input is_member, input top_slot,
                    input bottom_slot, input list_empty, output ready);
endinterface

[design/sol_ram.sv]
// Generic RAM: one write port, one read port, registered read data.
// No dependencies.
module sol_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/sol_fsm.sv]
// Request sequencer: idle, link read, two link write phases, finish.
// Depends on sol_pkg (state_t, ctrl_t).
module sol_fsm
    import sol_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_fire,
    input  logic  change,
    input  logic  out_free,
    output ctrl_t ctrl
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = change ? S_READ : S_FIN;
                end
            end
            S_READ:  state_next = S_WR1;
            S_WR1:   state_next = S_WR2;
            S_WR2:   state_next = S_FIN;
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl          = '0;
        ctrl.in_ready = (state_reg == S_IDLE);
        ctrl.rd_en    = (state_reg == S_READ);
        ctrl.wr1      = (state_reg == S_WR1);
        ctrl.wr2      = (state_reg == S_WR2);
        ctrl.finish   = (state_reg == S_FIN) && out_free;
    end

endmodule

[design/stacking_order_list_top.sv]
// Top level of the stacking order list: end registers, membership bits,
// link RAMs and response register. Depends on sol_pkg, sol_if, sol_ram, sol_fsm.
//
// Keeps a bottom-to-top list over SLOT_COUNT slots. Each request returns one
// response. A request that changes the list (valid remove or insert) goes from
// acceptance to the response register through one read of the link RAMs, two
// write phases and a finish state that waits for a free response register.
// There are two write phases because each of the above and below link RAMs has
// a single write port, and an insert writes up to two entries of each of them.
// A query or a rejected request goes straight to the finish state. The request
// channel is ready only between requests. A response waiting in the output
// register does not block the next request's link updates.
module stacking_order_list_top
    import sol_pkg::*;
#(
    parameter int SLOT_COUNT = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    sol_req_if.sink   req,
    sol_rsp_if.source rsp
);

    localparam int LW = $clog2(SLOT_COUNT + 1);
    localparam int AW = $clog2(SLOT_COUNT);
    localparam logic [LW-1:0] NO_SLOT = LW'(SLOT_COUNT);

    ctrl_t ctrl;
    logic  req_fire, out_free, change;

    logic [SLOT_COUNT-1:0] member_reg;
    logic [LW-1:0]         lowest_reg, highest_reg;
    op_t                   op_reg;
    logic [LW-1:0]         w_reg, x_reg;
    logic                  s_ok_reg;
    status_t               status_reg;

    logic    s_ok, r_ok, s_mem, r_mem;
    status_t status_new;

    logic          a_we, b_we, rd_en;
    logic [LW-1:0] a_waddr, b_waddr, a_wdata, b_wdata, rd_addr;
    logic [LW-1:0] a_rd, b_rd;

    logic                rsp_valid_reg;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic                rsp_member_reg, rsp_empty_reg;
    logic [SLOT_W-1:0]   rsp_top_reg, rsp_bottom_reg;

    assign req_fire  = req.valid && ctrl.in_ready;
    assign req.ready = ctrl.in_ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;

    // request checks against current membership
    always_comb
    begin
        s_ok  = (32'(req.slot) < SLOT_COUNT);
        r_ok  = (32'(req.reference_slot) < SLOT_COUNT);
        s_mem = s_ok && member_reg[AW'(req.slot)];
        r_mem = r_ok && member_reg[AW'(req.reference_slot)] && (req.reference_slot != req.slot);
        status_new = ST_OK;
        change     = 1'b0;
        unique case (req.op)
            OP_REMOVE:
            begin
                status_new = s_mem ? ST_OK : ST_MEMBER;
                change     = s_mem;
            end
            OP_TOP, OP_BOTTOM:
            begin
                status_new = (s_ok && !s_mem) ? ST_OK : ST_MEMBER;
                change     = s_ok && !s_mem;
            end
            OP_ABOVE, OP_BELOW:
            begin
                if (!s_ok || s_mem)
                begin
                    status_new = ST_MEMBER;
                end
                else if (!r_mem)
                begin
                    status_new = ST_REF;
                end
                else
                begin
                    change = 1'b1;
                end
            end
            default:
            begin
                status_new = ST_OK;
                change     = 1'b0;
            end
        endcase
    end

    sol_fsm u_fsm (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_fire (req_fire),
        .change   (change),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg     <= op_t'(req.op);
            w_reg      <= LW'(req.slot);
            x_reg      <= LW'(req.reference_slot);
            s_ok_reg   <= s_ok;
            status_reg <= status_new;
        end
    end

    // link RAM port control
    assign rd_en   = ctrl.rd_en && (op_reg == OP_REMOVE || op_reg == OP_ABOVE
                                    || op_reg == OP_BELOW);
    assign rd_addr = (op_reg == OP_REMOVE) ? w_reg : x_reg;

    always_comb
    begin
        a_we    = 1'b0;
        b_we    = 1'b0;
        a_waddr = w_reg;
        b_waddr = w_reg;
        a_wdata = NO_SLOT;
        b_wdata = NO_SLOT;
        if (ctrl.wr1)
        begin
            unique case (op_reg)
                OP_REMOVE:
                begin
                    b_we    = (a_rd < NO_SLOT);
                    b_waddr = a_rd;
                    b_wdata = b_rd;
                    a_we    = (b_rd < NO_SLOT);
                    a_waddr = b_rd;
                    a_wdata = a_rd;
                end
                OP_TOP:
                begin
                    a_we    = 1'b1;
                    a_wdata = NO_SLOT;
                    b_we    = 1'b1;
                    b_wdata = highest_reg;
                end
                OP_BOTTOM:
                begin
                    b_we    = 1'b1;
                    b_wdata = NO_SLOT;
                    a_we    = 1'b1;
                    a_wdata = lowest_reg;
                end
                OP_ABOVE:
                begin
                    b_we    = (a_rd < NO_SLOT);
                    b_waddr = a_rd;
                    b_wdata = w_reg;
                    a_we    = 1'b1;
                    a_wdata = a_rd;
                end
                OP_BELOW:
                begin
                    a_we    = (b_rd < NO_SLOT);
                    a_waddr = b_rd;
                    a_wdata = w_reg;
                    b_we    = 1'b1;
                    b_wdata = b_rd;
                end
                default:
                begin
                    a_we = 1'b0;
                    b_we = 1'b0;
                end
            endcase
        end
        else if (ctrl.wr2)
        begin
            unique case (op_reg)
                OP_TOP:
                begin
                    a_we    = (highest_reg < NO_SLOT);
                    a_waddr = highest_reg;
                    a_wdata = w_reg;
                end
                OP_BOTTOM:
                begin
                    b_we    = (lowest_reg < NO_SLOT);
                    b_waddr = lowest_reg;
                    b_wdata = w_reg;
                end
                OP_ABOVE:
                begin
                    a_we    = 1'b1;
                    a_waddr = x_reg;
                    a_wdata = w_reg;
                    b_we    = 1'b1;
                    b_wdata = x_reg;
                end
                OP_BELOW:
                begin
                    b_we    = 1'b1;
                    b_waddr = x_reg;
                    b_wdata = w_reg;
                    a_we    = 1'b1;
                    a_wdata = x_reg;
                end
                default:
                begin
                    a_we = 1'b0;
                    b_we = 1'b0;
                end
            endcase
        end
    end

    sol_ram #(.WIDTH(LW), .DEPTH(SLOT_COUNT)) u_above_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (AW'(a_waddr)),
        .wdata (a_wdata),
        .re    (rd_en),
        .raddr (AW'(rd_addr)),
        .rdata (a_rd)
    );

    sol_ram #(.WIDTH(LW), .DEPTH(SLOT_COUNT)) u_below_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (AW'(b_waddr)),
        .wdata (b_wdata),
        .re    (rd_en),
        .raddr (AW'(rd_addr)),
        .rdata (b_rd)
    );

    // ends and membership settle in the second write phase; read data still held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_reg  <= '0;
            lowest_reg  <= NO_SLOT;
            highest_reg <= NO_SLOT;
        end
        else if (ctrl.wr2)
        begin
            unique case (op_reg)
                OP_REMOVE:
                begin
                    member_reg[AW'(w_reg)] <= 1'b0;
                    if (lowest_reg == w_reg)
                    begin
                        lowest_reg <= a_rd;
                    end
                    if (highest_reg == w_reg)
                    begin
                        highest_reg <= b_rd;
                    end
                end
                OP_TOP:
                begin
                    member_reg[AW'(w_reg)] <= 1'b1;
                    highest_reg <= w_reg;
                    if (lowest_reg >= NO_SLOT)
                    begin
                        lowest_reg <= w_reg;
                    end
                end
                OP_BOTTOM:
                begin
                    member_reg[AW'(w_reg)] <= 1'b1;
                    lowest_reg <= w_reg;
                    if (highest_reg >= NO_SLOT)
                    begin
                        highest_reg <= w_reg;
                    end
                end
                OP_ABOVE:
                begin
                    member_reg[AW'(w_reg)] <= 1'b1;
                    if (highest_reg == x_reg)
                    begin
                        highest_reg <= w_reg;
                    end
                end
                OP_BELOW:
                begin
                    member_reg[AW'(w_reg)] <= 1'b1;
                    if (lowest_reg == x_reg)
                    begin
                        lowest_reg <= w_reg;
                    end
                end
                default:
                begin
                    member_reg <= member_reg;
                end
            endcase
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctrl.finish)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            rsp_status_reg <= status_reg;
            rsp_member_reg <= s_ok_reg && member_reg[AW'(w_reg)];
            rsp_top_reg    <= (highest_reg < NO_SLOT) ? SLOT_W'(highest_reg) : '0;
            rsp_bottom_reg <= (lowest_reg < NO_SLOT) ? SLOT_W'(lowest_reg) : '0;
            rsp_empty_reg  <= (lowest_reg >= NO_SLOT);
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.is_member   = rsp_member_reg;
    assign rsp.top_slot    = rsp_top_reg;
    assign rsp.bottom_slot = rsp_bottom_reg;
    assign rsp.list_empty  = rsp_empty_reg;

endmodule
